// File: rtl/core/lhb_pkg.sv
// Shared types and constants for the LATM header builder.
// No dependencies; used by the sequencer, the datapath and the top level.
package lhb_pkg;

  // Output buffer size in bytes; the header is cut to this many bytes.
  localparam int MAX_HEADER_BYTES = 30;
  // Longest header that a 12-bit payload size can produce.
  localparam int WORST_BYTES = 26;
  localparam int CAP_BYTES = (MAX_HEADER_BYTES < WORST_BYTES) ? MAX_HEADER_BYTES
                                                              : WORST_BYTES;
  // Fixed part (9 bytes) plus the remainder byte.
  localparam int BASE_BYTES = 10;
  localparam int CNT_W = $clog2(WORST_BYTES + 1);

  localparam int SIZE_W = 12;
  localparam int STEP_W = 4;

  localparam logic [7:0] BYTE_FF = 8'hFF;

  // config register indexes of the write port
  typedef enum logic [1:0] {
    REG_OBJECT_TYPE    = 2'd0,
    REG_SAMPLE_RATE    = 2'd1,
    REG_CHANNEL_LAYOUT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_WAIT,  // hold until a payload size arrives
    OP_EMIT,  // send one byte, then go on
    OP_LOOP   // send 0xFF while whole 255s remain, else jump
  } op_t;

  typedef enum logic [2:0] {
    SEL_CONST,
    SEL_ASC_HI,
    SEL_ASC_MID,
    SEL_ASC_LO,
    SEL_REM
  } sel_t;

  typedef struct packed {
    op_t              op;
    sel_t             sel;
    logic [7:0]       konst;
    logic [STEP_W-1:0] next_step;
  } ucode_t;

  // Sequencer -> datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic       loop;
    sel_t       sel;
    logic [7:0] konst;
  } seq_ctrl_t;

  // Datapath -> sequencer
  typedef struct packed {
    logic ff_zero;
    logic last;
    logic free;
  } dp_status_t;

  typedef struct packed {
    logic [4:0] object_type;
    logic [3:0] sample_rate_index;
    logic [3:0] channel_layout;
  } asc_cfg_t;

endpackage

// File: rtl/core/lhb_sequencer.sv
// Microcode ROM and step counter of the LATM header builder.
// Depends on lhb_pkg.
module lhb_sequencer import lhb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output seq_ctrl_t  ctrl
);

  localparam logic [STEP_W-1:0] IDLE_STEP = '0;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  logic              fire;

  // Program: wait, nine fixed bytes, 0xFF loop, remainder byte.
  always_comb begin
    uw = '{op: OP_EMIT, sel: SEL_CONST, konst: 8'h00, next_step: IDLE_STEP};
    case (step)
      4'd0:  uw = '{op: OP_WAIT, sel: SEL_CONST,   konst: 8'h00, next_step: 4'd1};
      4'd1:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'h47, next_step: 4'd2};
      4'd2:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'hFC, next_step: 4'd3};
      4'd3:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'h00, next_step: 4'd4};
      4'd4:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'h00, next_step: 4'd5};
      4'd5:  uw = '{op: OP_EMIT, sel: SEL_ASC_HI,  konst: 8'h00, next_step: 4'd6};
      4'd6:  uw = '{op: OP_EMIT, sel: SEL_ASC_MID, konst: 8'h00, next_step: 4'd7};
      4'd7:  uw = '{op: OP_EMIT, sel: SEL_ASC_LO,  konst: 8'h00, next_step: 4'd8};
      4'd8:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'h03, next_step: 4'd9};
      4'd9:  uw = '{op: OP_EMIT, sel: SEL_CONST,   konst: 8'h00, next_step: 4'd10};
      4'd10: uw = '{op: OP_LOOP, sel: SEL_CONST,   konst: BYTE_FF, next_step: 4'd11};
      4'd11: uw = '{op: OP_EMIT, sel: SEL_REM,     konst: 8'h00, next_step: IDLE_STEP};
      default: uw = '{op: OP_EMIT, sel: SEL_CONST, konst: 8'h00, next_step: IDLE_STEP};
    endcase
  end

  always_comb begin
    in_ready   = (uw.op == OP_WAIT);
    ctrl.load  = in_ready && in_valid;
    ctrl.emit  = (uw.op == OP_EMIT) || ((uw.op == OP_LOOP) && !status.ff_zero);
    ctrl.loop  = (uw.op == OP_LOOP);
    ctrl.sel   = uw.sel;
    ctrl.konst = uw.konst;
    fire       = ctrl.emit && status.free;
  end

  always_comb begin
    step_next = step;
    case (uw.op)
      OP_WAIT: begin
        if (ctrl.load) step_next = uw.next_step;
      end
      OP_EMIT: begin
        if (fire) step_next = status.last ? IDLE_STEP : uw.next_step;
      end
      OP_LOOP: begin
        if (status.ff_zero) begin
          step_next = uw.next_step;
        end else if (fire && status.last) begin
          step_next = IDLE_STEP;
        end
      end
      default: step_next = IDLE_STEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= IDLE_STEP;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/core/lhb_datapath.sv
// Byte datapath: length split, byte mux, byte counter and output register.
// Depends on lhb_pkg.
module lhb_datapath import lhb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  seq_ctrl_t         ctrl,
  input  logic [SIZE_W-1:0] size,
  input  asc_cfg_t          cfg,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic [7:0]        out_bits,
  output dp_status_t        status
);

  logic [SIZE_W:0]  quot_sum;
  logic [4:0]       full;
  logic [CNT_W-1:0] count_raw;
  logic [CNT_W-1:0] count_cap;

  logic [4:0]       ff_left;
  logic [7:0]       rem;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [7:0]       byte_mux;
  logic             fire;
  logic             last_now;

  // size / 255 for 12-bit sizes: (x + (x >> 8) + 1) >> 8
  always_comb begin
    quot_sum  = {1'b0, size} + {9'b0, size[SIZE_W-1:8]} + {{SIZE_W{1'b0}}, 1'b1};
    full      = quot_sum[SIZE_W:8];
    count_raw = CNT_W'(BASE_BYTES) + CNT_W'(full);
    count_cap = (count_raw > CNT_W'(CAP_BYTES)) ? CNT_W'(CAP_BYTES) : count_raw;
  end

  always_comb begin
    case (ctrl.sel)
      SEL_CONST:   byte_mux = ctrl.konst;
      SEL_ASC_HI:  byte_mux = {5'b10110, cfg.object_type[4:2]};
      SEL_ASC_MID: byte_mux = {cfg.object_type[1:0], cfg.sample_rate_index,
                               cfg.channel_layout[3:2]};
      SEL_ASC_LO:  byte_mux = {cfg.channel_layout[1:0], 6'b0};
      SEL_REM:     byte_mux = rem;
      default:     byte_mux = ctrl.konst;
    endcase
  end

  always_comb begin
    last_now       = ((idx + CNT_W'(1)) == count);
    status.ff_zero = (ff_left == '0);
    status.last    = last_now;
    status.free    = !out_valid || out_ready;
    fire           = ctrl.emit && status.free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ff_left <= full;
      // remainder low byte: size - 256*full + full
      rem     <= size[7:0] + {3'b0, full};
      count   <= count_cap;
      idx     <= '0;
    end else if (fire) begin
      idx <= idx + CNT_W'(1);
      if (ctrl.loop) ff_left <= ff_left - 5'd1;
    end
    if (fire) begin
      out_byte <= byte_mux;
      out_last <= last_now;
      out_bits <= {count, 3'b000};
    end
  end

endmodule

// File: rtl/core/latm_header_builder.sv
// Top level of the LATM AudioMuxElement header builder.
// Depends on lhb_pkg, lhb_sequencer and lhb_datapath.

// One transfer in carries a frame's payload size; the block then sends the
// header one byte per transfer, MSB-first in the stream: nine fixed bytes
// (StreamMuxConfig and AudioSpecificConfig from the config registers), one
// 0xFF byte per whole 255 of the size, and the remainder byte. tlast marks
// the final byte and every byte carries the header length in bits. A frame
// takes 10 to 26 output transfers, one per cycle when the sink never
// stalls; no byte is sent in the wait step, where the size is taken, nor
// when the 0xFF step finds no whole 255 left and jumps on. The microcode
// step counter sets the pace: it walks one step per byte sent outside the
// 0xFF loop and loops on the 0xFF step. Config registers may be written
// only between frames.
module latm_header_builder import lhb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] payload_size, [15:12] zero
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] header_byte, [15:8] header_bits
  output logic        m_axis_tlast    // last_byte
);

  asc_cfg_t   cfg;
  seq_ctrl_t  ctrl;
  dp_status_t status;
  logic [7:0] hdr_byte;
  logic [7:0] hdr_bits;

  // config registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.object_type       <= 5'd2;
      cfg.sample_rate_index <= 4'd4;
      cfg.channel_layout    <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OBJECT_TYPE:    cfg.object_type       <= cfg_data;
        REG_SAMPLE_RATE:    cfg.sample_rate_index <= cfg_data[3:0];
        REG_CHANNEL_LAYOUT: cfg.channel_layout    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lhb_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  lhb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .size      (s_axis_tdata[SIZE_W-1:0]),
    .cfg       (cfg),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_byte  (hdr_byte),
    .out_last  (m_axis_tlast),
    .out_bits  (hdr_bits),
    .status    (status)
  );

  assign m_axis_tdata = {hdr_bits, hdr_byte};

endmodule
